### design/vertex_project_clip_code_unit_defines.svh
// Assertion macros shared by the vertex projection checker.
// Depends on a clk_i and rst_ni in the scope of each use.
`ifndef VERTEX_PROJECT_CLIP_CODE_UNIT_DEFINES_SVH
`define VERTEX_PROJECT_CLIP_CODE_UNIT_DEFINES_SVH

// Check a condition on every clock edge out of reset
`define VPCC_ASSERT(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("vpcc check failed");

// Check that a trigger implies a consequence in the next cycle
`define VPCC_ASSERT_NEXT(name, trig, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("vpcc sequence check failed");

`endif

### design/vpcc_pkg.sv
// Types, constants and arithmetic helpers for the vertex projection unit.
// No dependencies.
package vpcc_pkg;

  // Clip-space values are saturated to +-(2^61 - 1), held in 62 bits
  localparam int CLIP_W = 62;
  localparam logic signed [63:0] SUM_MAX = 64'sh1FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_MIN = -64'sh1FFF_FFFF_FFFF_FFFF;

  // Divider widths: numerator and denominator below 2^63, dimension 17 bits
  localparam int DIV_W = 63;
  localparam int DIM_W = 17;
  localparam int Q_W   = 18;
  localparam int PIX_W = 12;

  // Outcode bit positions
  localparam int CLIP_LEFT   = 0;
  localparam int CLIP_RIGHT  = 1;
  localparam int CLIP_TOP    = 2;
  localparam int CLIP_BOTTOM = 3;
  localparam int CLIP_NEAR   = 4;
  localparam int CLIP_FAR    = 5;

  typedef enum logic [2:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_ROW3   = 3'd3,
    REG_WIDTH  = 3'd4,
    REG_HEIGHT = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [Q_W-1:0]   q;
  } div_lane_t;

  typedef struct packed {
    logic [5:0]       code;
    logic             vis;
    div_lane_t        x;
    div_lane_t        y;
    logic [DIV_W-1:0] nx;
    logic [DIV_W-1:0] ny;
    logic [DIV_W-1:0] den;
  } div_t;

  // Saturate a sum to the clip-space range
  function automatic logic signed [CLIP_W-1:0] clamp_sum(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > SUM_MAX) r = SUM_MAX;
    else if (v < SUM_MIN) r = SUM_MIN;
    else r = v;
    return r[CLIP_W-1:0];
  endfunction

  // One bit of floor(dim * num / den): double, then add num when the dim bit is set
  function automatic div_lane_t div_step(input div_lane_t s, input logic [DIV_W-1:0] num,
                                         input logic [DIV_W-1:0] den, input logic dbit);
    div_lane_t        r;
    logic [DIV_W-1:0] gap;
    r.q = s.q << 1;
    gap = den - s.rem;
    if (s.rem >= gap) begin
      r.rem  = s.rem - gap;
      r.q[0] = 1'b1;
    end else begin
      r.rem = s.rem + s.rem;
    end
    if (dbit) begin
      gap = den - r.rem;
      if (num >= gap) begin
        r.rem = num - gap;
        r.q   = r.q + Q_W'(1);
      end else begin
        r.rem = r.rem + num;
      end
    end
    return r;
  endfunction

endpackage

### design/vertex_project_clip_code_unit.sv
// Vertex projection unit: 4x4 transform, clip outcode and viewport mapping.
// Depends on vpcc_pkg.
//
// Takes one Q16.16 vertex per word and returns one result word per vertex:
// outcode, visible flag and pixel coordinates. A new vertex may enter every
// cycle while the output is not stalled, through one multiply stage, two summing
// stages, one outcode stage, a 17-stage pipelined divider (one quotient bit per
// stage, matching the 17-bit screen dimension) and the output register. When the
// output is stalled the whole pipeline holds. Matrix and screen registers sit
// on the 64-bit APB port at byte address 8*i; write them only while idle.
module vertex_project_clip_code_unit #(
  parameter int MAX_SCREEN_DIM = 4096,
  parameter int COORD_BITS     = 32
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // pos_x, pos_y, pos_z from the lowest bits up, zero padded to bytes
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // clip_code[5:0], visible[6], screen_x[18:7], screen_y[30:19], zero pad
  output logic [31:0]                              m_axis_tdata,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [5:0]                               paddr,
  input  logic [63:0]                              pwdata,
  output logic [63:0]                              prdata,
  output logic                                     pready
);

  localparam int PROD_W = COORD_BITS + 16;
  localparam int NSTG   = 4 + vpcc_pkg::DIM_W;
  localparam logic [vpcc_pkg::DIM_W-1:0] MAX_DIM = vpcc_pkg::DIM_W'(MAX_SCREEN_DIM);

  logic [63:0] row_q [4];
  logic [12:0] width_q, height_q;
  logic        adv;

  // Configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= 64'h0000_0000_0000_1000;
      row_q[1] <= 64'h0000_0000_1000_0000;
      row_q[2] <= 64'h0000_1000_0000_0000;
      row_q[3] <= 64'h1000_0000_0000_0000;
      width_q  <= 13'd640;
      height_q <= 13'd480;
    end else if (psel && penable && pwrite) begin
      unique case (vpcc_pkg::reg_idx_e'(paddr[5:3]))
        vpcc_pkg::REG_ROW0:   row_q[0] <= pwdata;
        vpcc_pkg::REG_ROW1:   row_q[1] <= pwdata;
        vpcc_pkg::REG_ROW2:   row_q[2] <= pwdata;
        vpcc_pkg::REG_ROW3:   row_q[3] <= pwdata;
        vpcc_pkg::REG_WIDTH:  width_q  <= pwdata[12:0];
        vpcc_pkg::REG_HEIGHT: height_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (vpcc_pkg::reg_idx_e'(paddr[5:3]))
      vpcc_pkg::REG_ROW0:   prdata = row_q[0];
      vpcc_pkg::REG_ROW1:   prdata = row_q[1];
      vpcc_pkg::REG_ROW2:   prdata = row_q[2];
      vpcc_pkg::REG_ROW3:   prdata = row_q[3];
      vpcc_pkg::REG_WIDTH:  prdata = 64'(width_q);
      vpcc_pkg::REG_HEIGHT: prdata = 64'(height_q);
      default:              prdata = '0;
    endcase
  end

  // Clamp dimensions to 1..MAX_SCREEN_DIM
  logic [vpcc_pkg::DIM_W-1:0] dim_x, dim_y;
  always_comb begin
    dim_x = vpcc_pkg::DIM_W'(width_q);
    dim_y = vpcc_pkg::DIM_W'(height_q);
    if (dim_x == '0) dim_x = vpcc_pkg::DIM_W'(1);
    if (dim_x > MAX_DIM) dim_x = MAX_DIM;
    if (dim_y == '0) dim_y = vpcc_pkg::DIM_W'(1);
    if (dim_y > MAX_DIM) dim_y = MAX_DIM;
  end

  // Advance the whole pipeline unless the output word is stalled
  logic [NSTG-1:0] v_q;
  logic            m_valid_q;
  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q       <= '0;
      m_valid_q <= 1'b0;
    end else if (adv) begin
      v_q       <= {v_q[NSTG-2:0], s_axis_tvalid};
      m_valid_q <= v_q[NSTG-1];
    end
  end

  // Stage 1: twelve products, each saturated
  logic signed [vpcc_pkg::CLIP_W-1:0] prod_q [3][4];
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 4; j++) begin : g_col
      logic signed [COORD_BITS-1:0] pos;
      logic signed [15:0]           ent;
      logic signed [PROD_W-1:0]     pr;
      assign pos = signed'(s_axis_tdata[i*COORD_BITS +: COORD_BITS]);
      assign ent = signed'(row_q[i][16*j +: 16]);
      assign pr  = pos * ent;
      always_ff @(posedge clk_i) begin
        if (adv) prod_q[i][j] <= vpcc_pkg::clamp_sum(64'(pr));
      end
    end
  end

  // Stages 2 and 3: accumulate in model order with saturation, carry the z product along
  logic signed [vpcc_pkg::CLIP_W-1:0] acc_q [4];
  logic signed [vpcc_pkg::CLIP_W-1:0] p2_q  [4];
  logic signed [vpcc_pkg::CLIP_W-1:0] c_q   [4];
  for (genvar j = 0; j < 4; j++) begin : g_sum
    logic signed [63:0]                 tr;
    logic signed [vpcc_pkg::CLIP_W-1:0] a0;
    assign tr = 64'(signed'(row_q[3][16*j +: 16])) <<< 16;
    assign a0 = vpcc_pkg::clamp_sum(tr + 64'(prod_q[0][j]));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        acc_q[j] <= vpcc_pkg::clamp_sum(64'(a0) + 64'(prod_q[1][j]));
        p2_q[j]  <= prod_q[2][j];
        c_q[j]   <= vpcc_pkg::clamp_sum(64'(acc_q[j]) + 64'(p2_q[j]));
      end
    end
  end

  // Stage 4: outcode, numerators and denominator
  vpcc_pkg::div_t d4_d, d4_q;
  always_comb begin
    logic signed [63:0] x, y, z, w;
    x = 64'(c_q[0]);
    y = 64'(c_q[1]);
    z = 64'(c_q[2]);
    w = 64'(c_q[3]);
    d4_d.code = '0;
    d4_d.code[vpcc_pkg::CLIP_LEFT]   = x < -w;
    d4_d.code[vpcc_pkg::CLIP_RIGHT]  = x > w;
    d4_d.code[vpcc_pkg::CLIP_BOTTOM] = y < -w;
    d4_d.code[vpcc_pkg::CLIP_TOP]    = y > w;
    d4_d.code[vpcc_pkg::CLIP_NEAR]   = z < 0;
    d4_d.code[vpcc_pkg::CLIP_FAR]    = z > w;
    d4_d.vis = (d4_d.code == '0) && (w > 0);
    d4_d.x   = '0;
    d4_d.y   = '0;
    d4_d.nx  = vpcc_pkg::DIV_W'(w + x);
    d4_d.ny  = vpcc_pkg::DIV_W'(w - y);
    d4_d.den = vpcc_pkg::DIV_W'(w <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) d4_q <= d4_d;
  end

  // Divider: one quotient bit per stage, most significant dimension bit first
  vpcc_pkg::div_t st_q [vpcc_pkg::DIM_W];
  for (genvar k = 0; k < vpcc_pkg::DIM_W; k++) begin : g_div
    vpcc_pkg::div_t prev, nxt;
    if (k == 0) begin : g_first
      assign prev = d4_q;
    end else begin : g_next
      assign prev = st_q[k-1];
    end
    always_comb begin
      nxt   = prev;
      nxt.x = vpcc_pkg::div_step(prev.x, prev.nx, prev.den, dim_x[vpcc_pkg::DIM_W-1-k]);
      nxt.y = vpcc_pkg::div_step(prev.y, prev.ny, prev.den, dim_y[vpcc_pkg::DIM_W-1-k]);
    end
    always_ff @(posedge clk_i) begin
      if (adv) st_q[k] <= nxt;
    end
  end

  // Output register: saturate at dim-1, zero coordinates when hidden
  vpcc_pkg::div_t              last;
  logic [vpcc_pkg::Q_W-1:0]    lim_x, lim_y, sat_x, sat_y;
  logic [31:0]                 out_d, out_q;
  assign last  = st_q[vpcc_pkg::DIM_W-1];
  assign lim_x = vpcc_pkg::Q_W'(dim_x) - vpcc_pkg::Q_W'(1);
  assign lim_y = vpcc_pkg::Q_W'(dim_y) - vpcc_pkg::Q_W'(1);
  assign sat_x = (last.x.q > lim_x) ? lim_x : last.x.q;
  assign sat_y = (last.y.q > lim_y) ? lim_y : last.y.q;
  assign out_d = {1'b0,
                  last.vis ? sat_y[vpcc_pkg::PIX_W-1:0] : '0,
                  last.vis ? sat_x[vpcc_pkg::PIX_W-1:0] : '0,
                  last.vis, last.code};

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end
  assign m_axis_tdata = out_q;

endmodule

### design/vpcc_checker.sv
// Port-level checks for the vertex projection unit, bound to the top level.
// Depends on vertex_project_clip_code_unit_defines.svh.
`include "vertex_project_clip_code_unit_defines.svh"

module vpcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // Hold a stalled result word
  `VPCC_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // Accept input exactly when the output side can move
  `VPCC_ASSERT(a_ready_follows_out, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  // Visible words carry a zero outcode
  `VPCC_ASSERT(a_vis_code, !(m_axis_tvalid && m_axis_tdata[6]) || (m_axis_tdata[5:0] == 6'd0))
  // Hidden words carry zero coordinates
  `VPCC_ASSERT(a_hidden_zero, !(m_axis_tvalid && !m_axis_tdata[6]) || (m_axis_tdata[30:7] == 24'd0))

endmodule

bind vertex_project_clip_code_unit vpcc_checker u_vpcc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

### tb/tb_vertex_project_clip_code_unit.sv
// Self-checking testbench for vertex_project_clip_code_unit: streams vertices
// through the transform, outcode and viewport stages and checks every word.
// Depends on vpcc_pkg and the unit itself.
module tb_vertex_project_clip_code_unit;

  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam longint     SUM_LIMIT  = 64'sh1FFF_FFFF_FFFF_FFFF;
  localparam int         DRAIN_CYC  = 40;

  typedef struct packed {
    logic [5:0]  code;
    logic        vis;
    logic [11:0] sx;
    logic [11:0] sy;
  } pixel_t;

  typedef struct {
    logic [31:0] x, y, z;
    bit          typed;
    pixel_t      want;
  } vec_row_t;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        psel, penable, pwrite, pready;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;

  // Shadow copy of the register file
  logic [63:0] mat_q [4];
  logic [12:0] width_q, height_q;

  pixel_t pixel_q[$];
  int     errors;
  int     burst_left;
  bit     hold_req;

  vertex_project_clip_code_unit DUT (.*);

  // Clock and timeout
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("tb_vertex_project_clip_code_unit: FAIL");
    $finish;
  end

  function automatic longint clamp61(longint v);
    if (v > SUM_LIMIT) return SUM_LIMIT;
    if (v < -SUM_LIMIT) return -SUM_LIMIT;
    return v;
  endfunction

  function automatic longint dim_of(logic [12:0] r);
    longint d;
    d = r;
    if (d < 1) d = 1;
    if (d > 4096) d = 4096;
    return d;
  endfunction

  // floor(dim * num / den), one quotient bit per dimension bit, saturated
  function automatic logic [11:0] fit_to_dim(bit [63:0] num, bit [63:0] den, bit [63:0] dim);
    bit [63:0] q, rem;
    q = 0;
    rem = 0;
    for (int b = 16; b >= 0; b--) begin
      q = q << 1;
      if (rem >= den - rem) begin
        rem = rem - (den - rem);
        q = q | 1;
      end else rem = rem + rem;
      if (dim[b]) begin
        if (num >= den - rem) begin
          rem = num - (den - rem);
          q = q + 1;
        end else rem = rem + num;
      end
    end
    if (q > dim - 1) q = dim - 1;
    return q[11:0];
  endfunction

  // Transform, outcode and viewport map of one vertex
  function automatic pixel_t project_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    longint p[3];
    longint c[4];
    longint acc;
    pixel_t r;
    p[0] = longint'($signed(px));
    p[1] = longint'($signed(py));
    p[2] = longint'($signed(pz));
    for (int j = 0; j < 4; j++) begin
      acc = clamp61(longint'($signed(mat_q[3][16*j +: 16])) * 65536);
      for (int i = 0; i < 3; i++)
        acc = clamp61(acc + clamp61(p[i] * longint'($signed(mat_q[i][16*j +: 16]))));
      c[j] = acc;
    end
    r = '0;
    r.code[vpcc_pkg::CLIP_LEFT]   = c[0] < -c[3];
    r.code[vpcc_pkg::CLIP_RIGHT]  = c[0] > c[3];
    r.code[vpcc_pkg::CLIP_BOTTOM] = c[1] < -c[3];
    r.code[vpcc_pkg::CLIP_TOP]    = c[1] > c[3];
    r.code[vpcc_pkg::CLIP_NEAR]   = c[2] < 0;
    r.code[vpcc_pkg::CLIP_FAR]    = c[2] > c[3];
    if (r.code == 6'd0 && c[3] > 0) begin
      r.vis = 1'b1;
      r.sx = fit_to_dim(c[3] + c[0], c[3] * 2, dim_of(width_q));
      r.sy = fit_to_dim(c[3] - c[1], c[3] * 2, dim_of(height_q));
    end
    return r;
  endfunction

  // APB write: setup, access and idle phases, shadow updated alongside
  task automatic reg_write(logic [2:0] idx, logic [63:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (idx <= vpcc_pkg::REG_ROW3) mat_q[idx] = v;
    else if (idx == vpcc_pkg::REG_WIDTH) width_q = v[12:0];
    else if (idx == vpcc_pkg::REG_HEIGHT) height_q = v[12:0];
  endtask

  // Offer one vertex in bursts with random gaps, queue its expected word
  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             bit typed = 0, pixel_t want = '0);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(0, 2);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixel_q.push_back(typed ? want : project_vertex(x, y, z));
  endtask

  // Hold the input until every expected word is out and the pipe is empty
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord(bit wild);
    if (wild) return $urandom;
    return $urandom_range(0, 32'h30000) - 32'h18000;
  endfunction

  function automatic logic [15:0] rand_entry(int lo, int hi);
    return 16'($urandom_range(0, hi - lo) + lo);
  endfunction

  // Near-identity projection with random content, so many points land visible
  task automatic load_sane_matrix();
    logic [63:0] row;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++)
        row[16*j +: 16] = (i == j) ? rand_entry(16'h0800, 16'h1800)
                                   : rand_entry(-16'h0200, 16'h0200);
      reg_write(3'(i), row);
    end
    row = {rand_entry(16'h0C00, 16'h2000), rand_entry(16'h0400, 16'h0C00),
           rand_entry(-16'h0400, 16'h0400), rand_entry(-16'h0400, 16'h0400)};
    reg_write(vpcc_pkg::REG_ROW3, row);
  endtask

  // Compare each delivered word with the oldest expectation
  always @(posedge clk_i) begin
    pixel_t got, exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[5:0], m_axis_tdata[6], m_axis_tdata[18:7], m_axis_tdata[30:19]};
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h", $time, m_axis_tdata);
      end else begin
        exp_w = pixel_q.pop_front();
        if (got.code !== exp_w.code) begin
          errors++;
          $display("%0t: clip_code exp %h got %h", $time, exp_w.code, got.code);
        end
        if (got.vis !== exp_w.vis) begin
          errors++;
          $display("%0t: visible exp %b got %b", $time, exp_w.vis, got.vis);
        end
        if (got.sx !== exp_w.sx) begin
          errors++;
          $display("%0t: screen_x exp %0d got %0d", $time, exp_w.sx, got.sx);
        end
        if (got.sy !== exp_w.sy) begin
          errors++;
          $display("%0t: screen_y exp %0d got %0d", $time, exp_w.sy, got.sy);
        end
      end
    end
  end

  // Receiver: stall patterns of its own, plus one long hold-off on request
  initial begin
    int mode, len;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 0;
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(5, 40);
        repeat (len) begin
          if (hold_req) break;
          m_axis_tready <= (mode == 0) ? 1'b1 :
                           (mode == 1) ? 1'($urandom_range(0, 1)) :
                                         ($urandom_range(0, 3) == 0);
          @(posedge clk_i);
        end
      end
    end
  end

  // Main sequence
  initial begin
    vec_row_t    dir_rows[$];
    logic [12:0] dims[6];
    errors = 0;
    burst_left = 0;
    hold_req = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mat_q[0] = 64'h1000;
    mat_q[1] = 64'h1000 << 16;
    mat_q[2] = 64'h1000 << 32;
    mat_q[3] = 64'h1000 << 48;
    width_q = 13'd640;
    height_q = 13'd480;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows under the reset identity and 640x480
    dir_rows = '{
      '{32'h0, 32'h0, 32'h8000, 1, '{6'h00, 1'b1, 12'd320, 12'd240}},
      '{32'h10000, 32'h0, 32'h8000, 1, '{6'h00, 1'b1, 12'd639, 12'd240}},
      '{32'h0, 32'hFFFF0000, 32'h8000, 1, '{6'h00, 1'b1, 12'd320, 12'd479}},
      '{32'hFFFF0000, 32'h10000, 32'h10000, 1, '{6'h00, 1'b1, 12'd0, 12'd0}},
      '{32'h0, 32'h0, 32'hFFFF8000, 1, '{6'h10, 1'b0, 12'd0, 12'd0}},
      '{32'h7FFFFFFF, 32'h0, 32'h0, 1, '{6'h02, 1'b0, 12'd0, 12'd0}},
      '{32'h80000000, 32'h7FFFFFFF, 32'h0, 1, '{6'h05, 1'b0, 12'd0, 12'd0}},
      '{32'h0, 32'h80000000, 32'h7FFFFFFF, 1, '{6'h28, 1'b0, 12'd0, 12'd0}},
      '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, '{6'h10, 1'b0, 12'd0, 12'd0}},
      '{32'h0, 32'h0, 32'h0, 0, '0},
      '{32'h1, 32'h1, 32'h1, 0, '0},
      '{32'h3, 32'hFFFF8001, 32'h0FFFF, 0, '0},
      '{32'h8000, 32'h8000, 32'h20000, 0, '0},
      '{32'hFFFF4000, 32'hFFFFC000, 32'h4000, 0, '0}
    };
    foreach (dir_rows[k])
      send_vertex(dir_rows[k].x, dir_rows[k].y, dir_rows[k].z,
                  dir_rows[k].typed, dir_rows[k].want);
    drain_pipe();

    // Zero matrix: W is zero, outcode zero yet not visible; also an ignored index
    for (int i = 0; i < 4; i++) reg_write(3'(i), 64'h0);
    reg_write(REG_UNUSED, 64'h1234);
    repeat (6) send_vertex(rand_coord(1), rand_coord(1), rand_coord(1));
    drain_pipe();

    // Random phases across dimension extremes and matrices
    dims = '{13'd0, 13'd1, 13'd4096, 13'd8191, 13'd4097, 13'd640};
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 4) begin
        for (int i = 0; i < 4; i++) reg_write(3'(i), {$urandom, $urandom});
      end else load_sane_matrix();
      reg_write(vpcc_pkg::REG_WIDTH,
                (ph < 6) ? 64'(dims[ph]) : 64'($urandom_range(1, 4096)));
      reg_write(vpcc_pkg::REG_HEIGHT,
                (ph < 6) ? 64'(dims[5 - ph]) : 64'($urandom_range(1, 4096)));
      if (ph == 3) hold_req = 1;
      repeat (60)
        send_vertex(rand_coord($urandom_range(0, 4) == 0),
                    rand_coord($urandom_range(0, 4) == 0),
                    rand_coord($urandom_range(0, 4) == 0));
      drain_pipe();
    end

    if (errors == 0) $display("tb_vertex_project_clip_code_unit: PASS");
    else $display("tb_vertex_project_clip_code_unit: FAIL");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/vpcc_pkg.sv
design/vertex_project_clip_code_unit.sv
design/vpcc_checker.sv
tb/tb_vertex_project_clip_code_unit.sv
